/* sv/package_instance_name_checker_macros.svh */
// Assertion macros shared by the name checker RTL.
`ifndef PACKAGE_INSTANCE_NAME_CHECKER_MACROS_SVH
`define PACKAGE_INSTANCE_NAME_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset (needs clk and arst_n in scope).
`define PINC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define PINC_ASSERT_NEVER(lbl, cond, msg) \
	`PINC_ASSERT(lbl, !(cond), msg)
`else
`define PINC_ASSERT(lbl, prop, msg)
`define PINC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* sv/pinc_pkg.sv */
// Types and constants of the package instance name checker.
package pinc_pkg;

	// Byte constants
	localparam logic [7:0] CHR_NUL  = 8'h00;
	localparam logic [7:0] CHR_DASH = 8'h2D;
	localparam logic [7:0] CHR_SEP  = 8'h5F;
	localparam logic [7:0] CHR_LO_A = 8'h61;
	localparam logic [7:0] CHR_LO_Z = 8'h7A;
	localparam logic [7:0] CHR_D0   = 8'h30;
	localparam logic [7:0] CHR_D9   = 8'h39;

	// Counter and register widths
	localparam int BASE_CNT_W = 6;
	localparam int KEY_CNT_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [BASE_CNT_W-1:0] BASE_LIMIT_RST = 6'd40;
	localparam logic [KEY_CNT_W-1:0]  KEY_LIMIT_RST  = 4'd10;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LIMIT  = 1'b1;

	// Byte class produced by the front end
	typedef enum logic [2:0] {
		CLS_LETTER,
		CLS_DIGIT,
		CLS_DASH,
		CLS_SEP,
		CLS_END,
		CLS_OTHER
	} cls_t;

	// Queue entry between front and back
	typedef struct packed {
		cls_t cls;
	} q_entry_t;

	// Name part being scanned
	typedef enum logic [1:0] {
		PART_BASE,
		PART_KEY,
		PART_EXTRA
	} part_t;

	// Base part fault; values match the verdict codes
	typedef enum logic [2:0] {
		BF_NONE,
		BF_LEAD,
		BF_TRAIL,
		BF_DOUBLE,
		BF_BAD
	} base_flt_t;

	// Verdict codes
	typedef enum logic [3:0] {
		FLT_NONE,
		FLT_LEAD_DASH,
		FLT_TRAIL_DASH,
		FLT_DOUBLE_DASH,
		FLT_BAD_BASE,
		FLT_NO_LETTER,
		FLT_BASE_LONG,
		FLT_BAD_KEY,
		FLT_KEY_EMPTY,
		FLT_KEY_LONG,
		FLT_EXTRA_SEP
	} fault_t;

endpackage

/* sv/pinc_if.sv */
// Valid/ready channel interfaces for name bytes and verdicts.
interface pinc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_byte;

	modport source (output valid, output name_byte, input ready);
	modport sink (input valid, input name_byte, output ready);
endinterface

interface pinc_out_if;
	import pinc_pkg::*;
	logic   valid;
	logic   ready;
	logic   name_ok;
	fault_t fault_code;
	logic   has_key;

	modport source (output valid, output name_ok, output fault_code, output has_key,
		input ready);
	modport sink (input valid, input name_ok, input fault_code, input has_key,
		output ready);
endinterface

/* sv/package_instance_name_checker.sv */
// Top level of the package instance name checker.
// Checks a name of the form base or base_key streamed one byte per beat; a zero byte ends
// the name and produces one verdict beat (name_ok, fault_code, has_key), other bytes produce
// none. The block takes one byte every cycle for as long as the verdict channel keeps up:
// the scanner in the back end updates its flags and counters once per cycle, and a verdict
// stalled on the output only holds back the next zero byte. That byte waits at the head of
// the queue with up to QUEUE_DEPTH-1 classified bytes behind it and one more in the
// classifier stage. A verdict is offered once its zero byte has passed the classifier stage
// and the queue; the result register loads as the beat leaves the queue.
// Limits are written through cfg_we/cfg_index/cfg_data (index 0 base limit, 1 key limit);
// the user must write them only while no name is in flight, as the block does not enforce it.
module package_instance_name_checker #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pinc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pinc_pkg::CFG_DATA_W-1:0]     cfg_data,
	pinc_in_if.sink                             name_chan,
	pinc_out_if.source                          verdict_chan
);
	import pinc_pkg::*;

	logic     fq_valid;
	logic     fq_ready;
	q_entry_t fq_entry;
	logic     qb_valid;
	logic     qb_ready;
	q_entry_t qb_entry;

	// Classifier
	pinc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.name_chan (name_chan),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_entry   (fq_entry)
	);

	// Decoupling queue
	pinc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_entry  (fq_entry),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_entry (qb_entry)
	);

	// Scanner and verdict
	pinc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_valid      (qb_valid),
		.q_ready      (qb_ready),
		.q_entry      (qb_entry),
		.verdict_chan (verdict_chan)
	);
endmodule

/* sv/pinc_front.sv */
// Front end: accepts name bytes and classifies them into the queue.
module pinc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	pinc_in_if.sink              name_chan,
	output logic                 q_valid,
	input  logic                 q_ready,
	output pinc_pkg::q_entry_t   q_entry
);
	import pinc_pkg::*;

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_in;

	// Byte classification
	always_comb begin
		if (name_chan.name_byte == CHR_NUL) begin
			cls_in = CLS_END;
		end else if (name_chan.name_byte == CHR_SEP) begin
			cls_in = CLS_SEP;
		end else if (name_chan.name_byte == CHR_DASH) begin
			cls_in = CLS_DASH;
		end else if (name_chan.name_byte >= CHR_LO_A && name_chan.name_byte <= CHR_LO_Z) begin
			cls_in = CLS_LETTER;
		end else if (name_chan.name_byte >= CHR_D0 && name_chan.name_byte <= CHR_D9) begin
			cls_in = CLS_DIGIT;
		end else begin
			cls_in = CLS_OTHER;
		end
	end

	// Stage register: takes a new beat whenever it is empty or drains
	assign name_chan.ready = !valid_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (name_chan.valid && name_chan.ready) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (name_chan.valid && name_chan.ready) begin
			cls_s1 <= cls_in;
		end
	end

	assign q_valid     = valid_s1;
	assign q_entry.cls = cls_s1;
endmodule

/* sv/pinc_fifo.sv */
// Short queue of classified bytes between front and back.
`include "package_instance_name_checker_macros.svh"
module pinc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pinc_pkg::q_entry_t   in_entry,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pinc_pkg::q_entry_t   out_entry
);
	import pinc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_entry = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PINC_ASSERT_NEVER(a_fifo_overfill, count_q > CNT_W'(DEPTH), "queue count beyond depth")
	`PINC_ASSERT(a_fifo_empty_ptrs, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "empty queue with pointers apart")
	`PINC_ASSERT(a_fifo_grow, (push && !pop) |=> (count_q == $past(count_q) + 1'b1), "queue count did not grow on push")
endmodule

/* sv/pinc_back.sv */
// Back end: scans classified bytes, holds the limits and delivers verdicts.
`include "package_instance_name_checker_macros.svh"
module pinc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pinc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pinc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                q_valid,
	output logic                                q_ready,
	input  pinc_pkg::q_entry_t                  q_entry,
	pinc_out_if.source                          verdict_chan
);
	import pinc_pkg::*;

	// Limit registers
	logic [BASE_CNT_W-1:0] base_limit_q;
	logic [KEY_CNT_W-1:0]  key_limit_q;

	// Scan state
	part_t                 part_q,      part_d;
	logic                  prev_dash_q, prev_dash_d;
	logic                  seen_let_q,  seen_let_d;
	logic [BASE_CNT_W-1:0] base_cnt_q,  base_cnt_d;
	logic [KEY_CNT_W-1:0]  key_cnt_q,   key_cnt_d;
	base_flt_t             base_flt_q,  base_flt_d;
	logic                  key_flt_q,   key_flt_d;

	// Result register
	logic   out_valid_q;
	logic   out_ok_q;
	fault_t out_code_q;
	logic   out_key_q;

	logic      pop;
	logic      pop_end;
	logic      alnum;
	base_flt_t bf_closed;
	base_flt_t bf_end;
	fault_t    code;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_limit_q <= BASE_LIMIT_RST;
			key_limit_q  <= KEY_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_BASE_LIMIT) begin
				base_limit_q <= cfg_data[BASE_CNT_W-1:0];
			end
			if (cfg_index == REG_KEY_LIMIT) begin
				key_limit_q <= cfg_data[KEY_CNT_W-1:0];
			end
		end
	end

	// Only an end-of-name beat needs the result slot
	assign q_ready = (q_entry.cls != CLS_END) || !out_valid_q || verdict_chan.ready;
	assign pop     = q_valid && q_ready;
	assign pop_end = pop && (q_entry.cls == CLS_END);
	assign alnum   = (q_entry.cls == CLS_LETTER) || (q_entry.cls == CLS_DIGIT);

	// Trailing dash check when the base part closes
	assign bf_closed = (base_flt_q == BF_NONE && prev_dash_q) ? BF_TRAIL : base_flt_q;
	assign bf_end    = (part_q == PART_BASE) ? bf_closed : base_flt_q;

	// Verdict in priority order
	always_comb begin
		if (part_q == PART_EXTRA) begin
			code = FLT_EXTRA_SEP;
		end else if (bf_end != BF_NONE) begin
			code = fault_t'({1'b0, bf_end});
		end else if (!seen_let_q) begin
			code = FLT_NO_LETTER;
		end else if (base_cnt_q > base_limit_q) begin
			code = FLT_BASE_LONG;
		end else if (part_q == PART_KEY && key_flt_q) begin
			code = FLT_BAD_KEY;
		end else if (part_q == PART_KEY && key_cnt_q == '0) begin
			code = FLT_KEY_EMPTY;
		end else if (part_q == PART_KEY && key_cnt_q > key_limit_q) begin
			code = FLT_KEY_LONG;
		end else begin
			code = FLT_NONE;
		end
	end

	// Next scan state
	always_comb begin
		part_d      = part_q;
		prev_dash_d = prev_dash_q;
		seen_let_d  = seen_let_q;
		base_cnt_d  = base_cnt_q;
		key_cnt_d   = key_cnt_q;
		base_flt_d  = base_flt_q;
		key_flt_d   = key_flt_q;
		case (q_entry.cls)
			CLS_END: begin
				part_d      = PART_BASE;
				prev_dash_d = 1'b0;
				seen_let_d  = 1'b0;
				base_cnt_d  = '0;
				key_cnt_d   = '0;
				base_flt_d  = BF_NONE;
				key_flt_d   = 1'b0;
			end
			CLS_SEP: begin
				if (part_q == PART_BASE) begin
					base_flt_d = bf_closed;
					part_d     = PART_KEY;
				end else begin
					part_d = PART_EXTRA;
				end
			end
			default: begin
				if (part_q == PART_BASE && base_flt_q == BF_NONE) begin
					if (alnum) begin
						seen_let_d  = seen_let_q || (q_entry.cls == CLS_LETTER);
						prev_dash_d = 1'b0;
						if (~&base_cnt_q) begin
							base_cnt_d = base_cnt_q + 1'b1;
						end
					end else if (q_entry.cls == CLS_DASH) begin
						if (base_cnt_q == '0) begin
							base_flt_d = BF_LEAD;
						end else if (prev_dash_q) begin
							base_flt_d = BF_DOUBLE;
						end else begin
							prev_dash_d = 1'b1;
							if (~&base_cnt_q) begin
								base_cnt_d = base_cnt_q + 1'b1;
							end
						end
					end else begin
						base_flt_d = BF_BAD;
					end
				end else if (part_q == PART_KEY) begin
					key_flt_d = key_flt_q || !alnum;
					if (~&key_cnt_q) begin
						key_cnt_d = key_cnt_q + 1'b1;
					end
				end
			end
		endcase
	end

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q      <= PART_BASE;
			prev_dash_q <= 1'b0;
			seen_let_q  <= 1'b0;
			base_cnt_q  <= '0;
			key_cnt_q   <= '0;
			base_flt_q  <= BF_NONE;
			key_flt_q   <= 1'b0;
		end else if (pop) begin
			part_q      <= part_d;
			prev_dash_q <= prev_dash_d;
			seen_let_q  <= seen_let_d;
			base_cnt_q  <= base_cnt_d;
			key_cnt_q   <= key_cnt_d;
			base_flt_q  <= base_flt_d;
			key_flt_q   <= key_flt_d;
		end
	end

	// Result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_end) begin
			out_valid_q <= 1'b1;
		end else if (verdict_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_end) begin
			out_ok_q   <= (code == FLT_NONE);
			out_code_q <= code;
			out_key_q  <= (part_q != PART_BASE);
		end
	end

	assign verdict_chan.valid      = out_valid_q;
	assign verdict_chan.name_ok    = out_ok_q;
	assign verdict_chan.fault_code = out_code_q;
	assign verdict_chan.has_key    = out_key_q;

	`PINC_ASSERT(a_back_rise_on_end, $rose(out_valid_q) |-> $past(pop_end), "verdict without end beat")
	`PINC_ASSERT_NEVER(a_back_dash_count, prev_dash_q && (base_cnt_q == '0), "dash noted with empty base")
	`PINC_ASSERT_NEVER(a_back_key_part, (key_cnt_q != '0) && (part_q == PART_BASE), "key bytes counted in base part")
endmodule

/* test/package_instance_name_checker_tb.sv */
// Self-checking testbench for the package instance name checker: byte stream in, verdicts out.
module package_instance_name_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pinc_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 270;
	localparam int MAX_REPORTS  = 10;

	// Bytes just outside the legal character ranges, plus the top-bit extremes
	localparam logic [7:0] EDGE_BYTES [6] = '{CHR_D0 - 8'd1, CHR_D9 + 8'd1, CHR_LO_A - 8'd1,
		CHR_LO_Z + 8'd1, 8'h80, 8'hFF};

	typedef struct packed {
		logic   ok;
		fault_t code;
		logic   key;
	} verdict_t;

	typedef logic [7:0] name_t[$];

	// Directed name: head, then fill copies of 'a', then tail; want is used when typed
	typedef struct {
		string    head;
		int       fill;
		string    tail;
		bit       typed;
		verdict_t want;
	} name_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pinc_in_if  name_chan ();
	pinc_out_if verdict_chan ();

	package_instance_name_checker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.name_chan    (name_chan),
		.verdict_chan (verdict_chan)
	);

	always #5 clk = ~clk;

	// Scanner copy: limits and per-name state
	logic [BASE_CNT_W-1:0] base_limit, base_cnt;
	logic [KEY_CNT_W-1:0]  key_limit, key_cnt;
	part_t                 part;
	base_flt_t             base_flt;
	bit                    prev_dash, seen_letter, key_bad;

	verdict_t expected_verdicts[$];
	int       errors, name_bytes, verdicts, settings, idle_cycles;
	bit [10:0] codes_seen;
	bit       tx_burst, rx_burst;
	bit       hold_req = 1'b0;

	name_row_t directed_names[$] = '{
		'{"",           0, "",     1, '{1'b0, FLT_NO_LETTER,   1'b0}},
		'{"abc",        0, "",     1, '{1'b1, FLT_NONE,        1'b0}},
		'{"-ab",        0, "",     1, '{1'b0, FLT_LEAD_DASH,   1'b0}},
		'{"ab-",        0, "",     1, '{1'b0, FLT_TRAIL_DASH,  1'b0}},
		'{"ab-_k",      0, "",     1, '{1'b0, FLT_TRAIL_DASH,  1'b1}},
		'{"a--b",       0, "",     1, '{1'b0, FLT_DOUBLE_DASH, 1'b0}},
		'{"a.b",        0, "",     1, '{1'b0, FLT_BAD_BASE,    1'b0}},
		'{"a\377b",     0, "",     1, '{1'b0, FLT_BAD_BASE,    1'b0}},
		'{"1.2",        0, "",     1, '{1'b0, FLT_BAD_BASE,    1'b0}},
		'{"123",        0, "",     1, '{1'b0, FLT_NO_LETTER,   1'b0}},
		'{"-a.b",       0, "",     1, '{1'b0, FLT_LEAD_DASH,   1'b0}},
		'{"",          41, "",     1, '{1'b0, FLT_BASE_LONG,   1'b0}},
		'{"",          40, "",     1, '{1'b1, FLT_NONE,        1'b0}},
		'{"",          41, "_-",   1, '{1'b0, FLT_BASE_LONG,   1'b1}},
		'{"ab_",        0, "",     1, '{1'b0, FLT_KEY_EMPTY,   1'b1}},
		'{"ab_c-d",     0, "",     1, '{1'b0, FLT_BAD_KEY,     1'b1}},
		'{"ab_\200",    0, "",     1, '{1'b0, FLT_BAD_KEY,     1'b1}},
		'{"ab_",       11, "",     1, '{1'b0, FLT_KEY_LONG,    1'b1}},
		'{"ab_",       10, "",     1, '{1'b1, FLT_NONE,        1'b1}},
		'{"-__",        0, "",     1, '{1'b0, FLT_EXTRA_SEP,   1'b1}},
		'{"a_b__\377x", 0, "",     1, '{1'b0, FLT_EXTRA_SEP,   1'b1}},
		'{"_",          0, "",     0, '0},
		'{"z9_0a",      0, "",     0, '0},
		'{"0-9a-z",     0, "",     0, '0},
		'{"`{/:",       0, "",     0, '0},
		'{"",          70, "_k",   0, '0}
	};

	function automatic void clear_scan();
		part        = PART_BASE;
		base_flt    = BF_NONE;
		prev_dash   = 1'b0;
		seen_letter = 1'b0;
		key_bad     = 1'b0;
		base_cnt    = '0;
		key_cnt     = '0;
	endfunction

	// A dash left hanging when the base part closes is a trailing dash
	function automatic void close_base();
		if (base_flt == BF_NONE && prev_dash)
			base_flt = BF_TRAIL;
	endfunction

	// Advance the scanner by one byte; returns 1 with the verdict when the byte ends a name
	function automatic bit scan_byte(input logic [7:0] b, output verdict_t v);
		bit letter, digit;
		letter = b >= CHR_LO_A && b <= CHR_LO_Z;
		digit  = b >= CHR_D0 && b <= CHR_D9;
		v = '0;
		if (b == CHR_NUL) begin
			if (part == PART_BASE)
				close_base();
			if (part == PART_EXTRA)
				v.code = FLT_EXTRA_SEP;
			else if (base_flt != BF_NONE)
				v.code = fault_t'({1'b0, base_flt});
			else if (!seen_letter)
				v.code = FLT_NO_LETTER;
			else if (base_cnt > base_limit)
				v.code = FLT_BASE_LONG;
			else if (part == PART_KEY && key_bad)
				v.code = FLT_BAD_KEY;
			else if (part == PART_KEY && key_cnt == 0)
				v.code = FLT_KEY_EMPTY;
			else if (part == PART_KEY && key_cnt > key_limit)
				v.code = FLT_KEY_LONG;
			else
				v.code = FLT_NONE;
			v.ok  = v.code == FLT_NONE;
			v.key = part != PART_BASE;
			clear_scan();
			return 1'b1;
		end
		if (b == CHR_SEP) begin
			if (part == PART_BASE) begin
				close_base();
				part = PART_KEY;
			end else begin
				part = PART_EXTRA;
			end
		end else if (part == PART_BASE && base_flt == BF_NONE) begin
			// Base scan stops at its first fault
			if (letter || digit) begin
				seen_letter |= letter;
				prev_dash = 1'b0;
				if (base_cnt != '1)
					base_cnt++;
			end else if (b == CHR_DASH) begin
				if (base_cnt == 0)
					base_flt = BF_LEAD;
				else if (prev_dash)
					base_flt = BF_DOUBLE;
				else begin
					prev_dash = 1'b1;
					if (base_cnt != '1)
						base_cnt++;
				end
			end else begin
				base_flt = BF_BAD;
			end
		end else if (part == PART_KEY) begin
			if (!(letter || digit))
				key_bad = 1'b1;
			if (key_cnt != '1)
				key_cnt++;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] rand_alnum();
		int r;
		r = $urandom_range(0, 35);
		return (r < 26) ? CHR_LO_A + 8'(r) : CHR_D0 + 8'(r - 26);
	endfunction

	function automatic logic [7:0] rand_letter();
		return CHR_LO_A + 8'($urandom_range(0, 25));
	endfunction

	// Random name, zero-terminated: mostly well-formed with the odd flaw, some noise
	function automatic name_t make_name();
		name_t q;
		int    kind, blen, klen, pos;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			blen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 70) :
				$urandom_range(1, int'(base_limit) + 2);
			for (int i = 0; i < blen; i++) begin
				if (i > 0 && i < blen - 1 && q[i-1] != CHR_DASH && $urandom_range(0, 4) == 0)
					q.push_back(CHR_DASH);
				else
					q.push_back(rand_alnum());
			end
			if ($urandom_range(0, 9) != 0)
				q[$urandom_range(0, blen - 1)] = rand_letter();
			if ($urandom_range(0, 1) == 1) begin
				q.push_back(CHR_SEP);
				klen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) :
					$urandom_range(0, int'(key_limit) + 2);
				repeat (klen) q.push_back(rand_alnum());
			end
			// Occasional single flaw in an otherwise good name
			if ($urandom_range(0, 2) == 0) begin
				pos = $urandom_range(0, q.size() - 1);
				case ($urandom_range(0, 4))
					0: q[pos] = 8'($urandom_range(1, 255));
					1: q.insert(pos, CHR_SEP);
					2: q.push_front(CHR_DASH);
					3: q.push_back(CHR_DASH);
					default: begin
						q.insert(pos, CHR_DASH);
						q.insert(pos, CHR_DASH);
					end
				endcase
			end
		end else if (kind <= 7) begin
			repeat ($urandom_range(0, 12)) begin
				case ($urandom_range(0, 5))
					0, 1: q.push_back(rand_alnum());
					2: q.push_back(CHR_DASH);
					3: q.push_back(CHR_SEP);
					4: q.push_back(EDGE_BYTES[$urandom_range(0, 5)]);
					default: q.push_back(8'($urandom_range(1, 255)));
				endcase
			end
		end else if (kind == 8) begin
			repeat ($urandom_range(0, 20)) q.push_back(8'($urandom_range(1, 255)));
		end else begin
			// Long names can run the counters into saturation
			repeat ($urandom_range(55, 70)) q.push_back(rand_alnum());
			if ($urandom_range(0, 1) == 1) begin
				q.push_back(CHR_SEP);
				repeat ($urandom_range(12, 18)) q.push_back(rand_alnum());
			end
		end
		q.push_back(CHR_NUL);
		return q;
	endfunction

	// One input beat with a random lead-in gap; predicts on acceptance
	task automatic send_byte(input logic [7:0] b, input bit typed, input verdict_t want);
		int       gap;
		verdict_t v;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			name_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		name_chan.valid     <= 1'b1;
		name_chan.name_byte <= b;
		do @(posedge clk); while (!(name_chan.valid && name_chan.ready));
		name_bytes++;
		if (scan_byte(b, v))
			expected_verdicts.push_back(typed ? want : v);
	endtask

	task automatic send_name(input name_t q, input bit typed, input verdict_t want, input bit burst);
		tx_burst = burst || $urandom_range(0, 4) == 0;
		foreach (q[i])
			send_byte(q[i], typed, want);
	endtask

	task automatic idle_until_drained();
		name_chan.valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both limit registers, back to back, while the block is idle
	task automatic set_limits(input int base_val, input int key_val);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE_LIMIT;
		cfg_data  <= base_val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= REG_KEY_LIMIT;
		cfg_data  <= CFG_DATA_W'(key_val[KEY_CNT_W-1:0]);
		@(posedge clk);
		cfg_we     <= 1'b0;
		base_limit = base_val[BASE_CNT_W-1:0];
		key_limit  = key_val[KEY_CNT_W-1:0];
		settings++;
	endtask

	task automatic note_error(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// Stimulus: directed names at reset limits, then random phases over several limit pairs
	initial begin
		int       base_set[6], key_set[6], start;
		name_t    q;
		verdict_t none;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_BASE_LIMIT;
		cfg_data            = '0;
		name_chan.valid     = 1'b0;
		name_chan.name_byte = CHR_NUL;
		base_limit          = BASE_LIMIT_RST;
		key_limit           = KEY_LIMIT_RST;
		none                = '0;
		clear_scan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_names[i]) begin
			q = {};
			for (int j = 0; j < directed_names[i].head.len(); j++)
				q.push_back(directed_names[i].head[j]);
			repeat (directed_names[i].fill) q.push_back(CHR_LO_A);
			for (int j = 0; j < directed_names[i].tail.len(); j++)
				q.push_back(directed_names[i].tail[j]);
			q.push_back(CHR_NUL);
			send_name(q, directed_names[i].typed, directed_names[i].want, 1'b0);
		end
		idle_until_drained();

		base_set = '{1, 62, 63, $urandom_range(1, 63), 7, $urandom_range(2, 61)};
		key_set  = '{1, 14, 15, $urandom_range(1, 15), 2, $urandom_range(3, 13)};
		for (int p = 0; p < 6; p++) begin
			set_limits(base_set[p], key_set[p]);
			start = name_bytes;
			// Back-pressure: receiver holds off while short names stream in without gaps
			if (p == 1) begin
				hold_req = 1'b1;
				repeat (12) begin
					q = {};
					q.push_back(rand_alnum());
					q.push_back(rand_letter());
					q.push_back(CHR_NUL);
					send_name(q, 1'b0, none, 1'b1);
				end
			end
			while (name_bytes - start < PHASE_BYTES)
				send_name(make_name(), 1'b0, none, 1'b0);
			idle_until_drained();
		end

		$display("Checked %0d name bytes and %0d verdicts across %0d limit settings",
			name_bytes, verdicts, settings + 1);
		$display("%0d of 11 fault codes observed, including a long output stall",
			$countones(codes_seen));
		if (errors == 0 && expected_verdicts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Verdict receiver: random stalls, quiet stretches, one long hold on request
	initial begin
		int wait_cycles;
		verdict_chan.ready = 1'b0;
		rx_burst           = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				wait_cycles = HOLD_CYCLES;
				hold_req    = 1'b0;
			end else begin
				wait_cycles = rx_burst ? 0 : $urandom_range(0, 10);
			end
			if ($urandom_range(0, 31) == 0)
				rx_burst = !rx_burst;
			if (wait_cycles != 0) begin
				verdict_chan.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			verdict_chan.ready <= 1'b1;
			do @(posedge clk); while (!(verdict_chan.valid && verdict_chan.ready));
		end
	end

	// Compare each verdict beat with the oldest expectation
	always @(posedge clk) begin
		verdict_t want, got;
		if (arst_n && verdict_chan.valid && verdict_chan.ready) begin
			verdicts++;
			got = {verdict_chan.name_ok, verdict_chan.fault_code, verdict_chan.has_key};
			if (got.code <= FLT_EXTRA_SEP)
				codes_seen[got.code] = 1'b1;
			if (expected_verdicts.size() == 0) begin
				note_error($sformatf("Unexpected verdict beat: ok=%0b code=%0d key=%0b",
					got.ok, got.code, got.key));
			end else begin
				want = expected_verdicts.pop_front();
				if (got.ok !== want.ok || got.code !== want.code || got.key !== want.key)
					note_error($sformatf(
						"Verdict %0d mismatch: expected ok=%0b code=%0d key=%0b, got ok=%0b code=%0d key=%0b",
						verdicts, want.ok, want.code, want.key, got.ok, got.code, got.key));
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (name_chan.valid && name_chan.ready) ||
				(verdict_chan.valid && verdict_chan.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
